// ===== rtl/core/dht_pkg.sv =====
// Shared types and codes for the descriptor/handle table.
// Depends on nothing; every module of the block imports it.
`default_nettype none
package dht_pkg;

    localparam int HANDLE_W = 31;
    localparam int FD_W     = 32;
    localparam int FDOUT_W  = 6;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_OPEN   = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_CLOSE  = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_BADFD = 2'd2
    } t_status;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle_in;
        logic signed [FD_W-1:0] user_fd;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FDOUT_W-1:0]  fd_out;
        logic [HANDLE_W-1:0] handle_out;
    } t_rsp;

endpackage
`default_nettype wire

// ===== rtl/core/descriptor_handle_table.sv =====
// Top level of the descriptor/handle table: request decode and result stage.
// Depends on dht_pkg, dht_used and dht_mem.
//
// Usage:
//   A request beat is taken at a rising edge with start high and busy low.
//   kind selects open (store i_req.handle_in in the lowest free slot and
//   return FIRST_FD plus the slot), lookup (return the stored handle) or
//   close (lookup, then free the slot on success).
//   The answer appears in the cycle after the accept, for exactly one cycle,
//   flagged by o_strobe; the handle memory's registered read sets that
//   delay. busy is high during the result cycle, so no new request is taken
//   until the answer has been given.
//   In-use bits and slot allocation update at the accept edge; the handle
//   is read from memory and muxed onto o_result in the cycle after.
//   The receiver cannot stall: o_result is valid only while o_strobe is high.
//   Reset (i_rst_n low, synchronous) frees every slot and drops any request
//   in flight; the handle memory is not cleared, it is only read for slots
//   that an open has written.
`default_nettype none
module descriptor_handle_table #(
    parameter int SLOTS    = 32,
    parameter int FIRST_FD = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire dht_pkg::t_req i_req,
    output logic               o_strobe,
    output dht_pkg::t_rsp      o_result
);
    import dht_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic                 w_accept;
    logic signed [FD_W:0] w_off;
    logic                 w_in_range;
    logic [SW-1:0]        w_slot;
    logic                 w_query_used;
    logic                 w_free_found;
    logic [SW-1:0]        w_free_idx;
    logic                 w_set;
    logic                 w_clr;
    logic [SW-1:0]        w_idx;
    logic [HANDLE_W-1:0]  w_rdata;

    logic                 r_busy;
    logic [STATUS_W-1:0]  r_status;
    logic [FDOUT_W-1:0]   r_fd;
    logic                 r_ret_handle;
    logic [STATUS_W-1:0]  n_status;
    logic [FDOUT_W-1:0]   n_fd;
    logic                 n_ret_handle;

    assign w_accept   = start && !r_busy;
    assign w_off      = {i_req.user_fd[FD_W-1], i_req.user_fd} - (FD_W+1)'(FIRST_FD);
    assign w_in_range = !w_off[FD_W] && (w_off < (FD_W+1)'(SLOTS));
    assign w_slot     = w_off[SW-1:0];

    dht_used #(.SLOTS(SLOTS), .SW(SW)) u_used (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_set        (w_set),
        .i_clr        (w_clr),
        .i_idx        (w_idx),
        .i_query_idx  (w_slot),
        .o_query_used (w_query_used),
        .o_free_found (w_free_found),
        .o_free_idx   (w_free_idx)
    );

    dht_mem #(.SLOTS(SLOTS), .SW(SW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_set),
        .i_waddr (w_free_idx),
        .i_wdata (i_req.handle_in),
        .i_raddr (w_slot),
        .o_rdata (w_rdata)
    );

    // decode the request beat
    always_comb begin
        w_set        = 1'b0;
        w_clr        = 1'b0;
        w_idx        = w_slot;
        n_status     = ST_BADFD;
        n_fd         = '0;
        n_ret_handle = 1'b0;
        case (t_kind'(i_req.kind))
            KIND_OPEN: begin
                w_idx = w_free_idx;
                if (w_free_found) begin
                    w_set    = w_accept;
                    n_status = ST_OK;
                    n_fd     = FDOUT_W'(FIRST_FD + int'(w_free_idx));
                end else begin
                    n_status = ST_FULL;
                end
            end
            KIND_LOOKUP, KIND_CLOSE: begin
                if (w_in_range && w_query_used) begin
                    n_status     = ST_OK;
                    n_ret_handle = 1'b1;
                    w_clr        = w_accept && (t_kind'(i_req.kind) == KIND_CLOSE);
                end
            end
            default: begin
                n_status = ST_BADFD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= w_accept;
        end
    end

    // hold the decoded answer until the handle read returns
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_status;
            r_fd         <= n_fd;
            r_ret_handle <= n_ret_handle;
        end
    end

    assign busy                = r_busy;
    assign o_strobe            = r_busy;
    assign o_result.status     = r_status;
    assign o_result.fd_out     = r_fd;
    assign o_result.handle_out = r_ret_handle ? w_rdata : '0;

endmodule
`default_nettype wire

// ===== rtl/core/dht_used.sv =====
// In-use bits of the table with a lowest-free-slot priority encoder.
// Depends on dht_pkg for shared conventions.
`default_nettype none
module dht_used #(
    parameter int SLOTS = 32,
    parameter int SW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_set,
    input  wire logic          i_clr,
    input  wire logic [SW-1:0] i_idx,
    input  wire logic [SW-1:0] i_query_idx,
    output logic               o_query_used,
    output logic               o_free_found,
    output logic [SW-1:0]      o_free_idx
);
    import dht_pkg::*;

    logic [SLOTS-1:0] r_used;

    // scan from the top so the lowest free slot wins
    always_comb begin
        o_free_found = 1'b0;
        o_free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                o_free_found = 1'b1;
                o_free_idx   = SW'(i);
            end
        end
    end

    assign o_query_used = r_used[i_query_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_set) begin
            r_used[i_idx] <= 1'b1;
        end else if (i_clr) begin
            r_used[i_idx] <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dht_mem.sv =====
// Handle store: single write port, one read port with registered data.
// Depends on dht_pkg for the handle width.
`default_nettype none
module dht_mem #(
    parameter int SLOTS = 32,
    parameter int SW    = 5
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [SW-1:0]                i_waddr,
    input  wire logic [dht_pkg::HANDLE_W-1:0] i_wdata,
    input  wire logic [SW-1:0]                i_raddr,
    output logic      [dht_pkg::HANDLE_W-1:0] o_rdata
);
    import dht_pkg::*;

    logic [HANDLE_W-1:0] mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire
